// ===== rtl/byte_ring_buffer_with_peek_defines.svh =====
// Assertion macros for the byte ring buffer with peek.
`ifndef BYTE_RING_BUFFER_WITH_PEEK_DEFINES_SVH
`define BYTE_RING_BUFFER_WITH_PEEK_DEFINES_SVH

// check a property outside reset
`define BRB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define BRB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/brb_pkg.sv =====
// Package for the byte ring buffer with peek: widths, defaults and request modes.
package brb_pkg;

  localparam int DEPTH_DEF   = 4096;
  localparam int MAX_RUN_DEF = 64;

  localparam int MODE_W = 2;
  localparam int DATA_W = 8;
  localparam int LEN_W  = 7;
  localparam int OFF_W  = 12;
  localparam int LVL_W  = 12;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_PEEK    = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_t;

  typedef struct packed {
    logic             rd;
    logic             last;
    logic [LEN_W-1:0] count;
    logic [LVL_W-1:0] level;
  } elem_t;

endpackage

// ===== rtl/byte_ring_buffer_with_peek.sv =====
// Byte ring buffer with write, read, peek and discard requests over one byte store.
//
//   channel | direction | handshake          | fields
//   in      | request   | in_valid/in_stall   | mode, data_in, length, offset
//   out     | result    | out_valid/out_stall | byte_out, last, count, used_level
//
// A write or an empty run gives its single result in the cycle after the request.
// A run of n bytes gives one result per cycle while the output is not stalled;
// the single read port of the byte store has registered read data, the output byte.
// The next request is taken once the final result is loaded and the output can advance.
// Reset clears the pointers and the output stage; the store is not cleared.
// A stalled result holds the whole pipeline, store read included.
`include "byte_ring_buffer_with_peek_defines.svh"

module byte_ring_buffer_with_peek #(
  parameter int DEPTH   = brb_pkg::DEPTH_DEF,
  parameter int MAX_RUN = brb_pkg::MAX_RUN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [brb_pkg::MODE_W-1:0]  mode,
  input  logic [brb_pkg::DATA_W-1:0]  data_in,
  input  logic [brb_pkg::LEN_W-1:0]   length,
  input  logic [brb_pkg::OFF_W-1:0]   offset,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [brb_pkg::DATA_W-1:0]  byte_out,
  output logic                        last,
  output logic [brb_pkg::LEN_W-1:0]   count,
  output logic [brb_pkg::LVL_W-1:0]   used_level
);

  localparam int AW = $clog2(DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = (PW > brb_pkg::OFF_W) ? PW : brb_pkg::OFF_W;
  localparam int SW = CW + 1;
  localparam int LW = brb_pkg::LEN_W;

  localparam logic [PW-1:0] PTR_LAST  = PW'(2 * DEPTH - 1);
  localparam logic [PW-1:0] PTR_DEPTH = PW'(DEPTH);
  localparam logic [AW-1:0] SLOT_LAST = AW'(DEPTH - 1);
  localparam logic [SW-1:0] S_DEPTH   = SW'(DEPTH);
  localparam logic [SW-1:0] S_MOD     = SW'(2 * DEPTH);
  localparam logic [LW-1:0] RUN_MAX   = LW'(MAX_RUN);

  logic [brb_pkg::DATA_W-1:0] byte_store [DEPTH];
  logic [brb_pkg::DATA_W-1:0] rd_data;

  logic [PW-1:0] head, tail;
  logic [PW-1:0] head_next, tail_next;
  logic [LW-1:0] run_rem, rem_next;
  logic [AW-1:0] run_addr, addr_next;
  logic          run_rd;
  logic [LW-1:0] run_count;
  logic [brb_pkg::LVL_W-1:0] run_level;
  brb_pkg::elem_t out_elem;

  logic          accept, adv, busy;
  logic          wr_en, rd_en, full;
  logic [AW-1:0] head_slot, tail_slot;
  logic [SW-1:0] used, diff, avail, ssum, tsum;
  logic [LW-1:0] len_c, n;
  brb_pkg::mode_t mode_c;

  brb_pkg::elem_t f_elem, e_elem;
  logic [AW-1:0]  f_addr, e_addr;
  logic [LW-1:0]  f_rem;
  logic           e_valid;

  function automatic logic [AW-1:0] slot_of(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= PTR_DEPTH) ? p - PTR_DEPTH : p;
    return s[AW-1:0];
  endfunction

  assign busy     = run_rem != '0;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = busy || !adv;
  assign accept   = in_valid && !in_stall;
  assign mode_c   = brb_pkg::mode_t'(mode);

  assign head_slot = slot_of(head);
  assign tail_slot = slot_of(tail);

  always_comb begin
    diff = (head >= tail) ? SW'(head) - SW'(tail) : SW'(head) + S_MOD - SW'(tail);
    used = (diff > S_DEPTH) ? diff - S_DEPTH : diff;
    full = used >= S_DEPTH - SW'(1);
    len_c = (length > RUN_MAX) ? RUN_MAX : length;
    ssum = SW'(tail_slot) + SW'(offset);
    avail = used - SW'(offset);

    n         = '0;
    f_addr    = tail_slot;
    f_elem    = '0;
    wr_en     = 1'b0;
    head_next = head;
    tail_next = tail;

    unique case (mode_c)
      brb_pkg::MODE_WRITE: begin
        f_elem.last  = 1'b1;
        f_elem.count = full ? LW'(0) : LW'(1);
        f_elem.level = full ? brb_pkg::LVL_W'(used) : brb_pkg::LVL_W'(used + SW'(1));
        wr_en        = accept && !full;
        if (!full) begin
          head_next = (head == PTR_LAST) ? '0 : head + PW'(1);
        end
      end
      brb_pkg::MODE_PEEK: begin
        if (SW'(offset) >= used) begin
          n = '0;
        end else begin
          n = (avail > SW'(len_c)) ? len_c : LW'(avail);
        end
        f_addr       = (ssum >= S_DEPTH) ? AW'(ssum - S_DEPTH) : AW'(ssum);
        f_elem.rd    = n != '0;
        f_elem.last  = n <= LW'(1);
        f_elem.count = n;
        f_elem.level = brb_pkg::LVL_W'(used);
      end
      brb_pkg::MODE_READ, brb_pkg::MODE_DISCARD: begin
        n            = (used > SW'(len_c)) ? len_c : LW'(used);
        f_elem.rd    = (mode_c == brb_pkg::MODE_READ) && (n != '0);
        f_elem.last  = n <= LW'(1);
        f_elem.count = n;
        f_elem.level = brb_pkg::LVL_W'(used - SW'(n));
      end
      default: begin
        n = '0;
      end
    endcase

    tsum = SW'(tail) + SW'(n);
    if (mode_c == brb_pkg::MODE_READ || mode_c == brb_pkg::MODE_DISCARD) begin
      tail_next = (tsum >= S_MOD) ? PW'(tsum - S_MOD) : PW'(tsum);
    end
    f_rem = (n != '0) ? n - LW'(1) : '0;

    if (busy) begin
      e_valid      = 1'b1;
      e_elem.rd    = run_rd;
      e_elem.last  = run_rem == LW'(1);
      e_elem.count = run_count;
      e_elem.level = run_level;
      e_addr       = run_addr;
      rem_next     = run_rem - LW'(1);
    end else begin
      e_valid  = accept;
      e_elem   = f_elem;
      e_addr   = f_addr;
      rem_next = accept ? f_rem : '0;
    end
    addr_next = (e_addr == SLOT_LAST) ? '0 : e_addr + AW'(1);
    rd_en     = adv && e_valid && e_elem.rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      run_rem   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        head <= head_next;
        tail <= tail_next;
      end
      if (adv) begin
        out_valid <= e_valid;
        run_rem   <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && e_valid) begin
      out_elem <= e_elem;
      run_addr <= addr_next;
    end
    if (accept) begin
      run_rd    <= f_elem.rd;
      run_count <= f_elem.count;
      run_level <= f_elem.level;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_store[head_slot] <= data_in;
    end
    if (rd_en) begin
      rd_data <= byte_store[e_addr];
    end
  end

  assign byte_out   = out_elem.rd ? rd_data : '0;
  assign last       = out_elem.last;
  assign count      = out_elem.count;
  assign used_level = out_elem.level;

  `BRB_ASSERT(a_level_below_depth, clk, rst, used < S_DEPTH, "fill level reached depth")
  `BRB_ASSERT(a_run_has_result, clk, rst, busy |-> out_valid, "run active without a result")
  `BRB_ASSERT(a_run_continues, clk, rst, out_valid && !last |=> out_valid, "run broken early")
  `BRB_ASSERT_ALWAYS(a_port_exclusive, clk, !(wr_en && rd_en), "store written and read at once")

endmodule

// ===== verif/brb_checker.sv =====
// Result checker for the byte ring buffer: predicts every result from accepted requests.
module brb_checker #(
  parameter int DEPTH   = brb_pkg::DEPTH_DEF,
  parameter int MAX_RUN = brb_pkg::MAX_RUN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [brb_pkg::MODE_W-1:0] mode,
  input  logic [brb_pkg::DATA_W-1:0] data_in,
  input  logic [brb_pkg::LEN_W-1:0]  length,
  input  logic [brb_pkg::OFF_W-1:0]  offset,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [brb_pkg::DATA_W-1:0] byte_out,
  input  logic                       last,
  input  logic [brb_pkg::LEN_W-1:0]  count,
  input  logic [brb_pkg::LVL_W-1:0]  used_level,
  output int                         fail_count,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PTR_MOD = 2 * DEPTH;
  localparam int AW      = $clog2(DEPTH);

  typedef struct packed {
    logic [brb_pkg::DATA_W-1:0] data;
    logic                       fin;
    logic [brb_pkg::LEN_W-1:0]  cnt;
    logic [brb_pkg::LVL_W-1:0]  lvl;
  } result_t;

  logic [brb_pkg::DATA_W-1:0] byte_mem [0:DEPTH-1];
  int                         head_ptr = 0;
  int                         tail_ptr = 0;
  int                         mismatches = 0;
  result_t                    expected_bytes [$];

  assign fail_count = mismatches;

  function automatic int held_bytes();
    int u;
    u = (head_ptr + PTR_MOD - tail_ptr) % PTR_MOD;
    if (u > DEPTH) u -= DEPTH;
    return u;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic predict_request(input logic [brb_pkg::MODE_W-1:0] m,
                                 input logic [brb_pkg::DATA_W-1:0] d,
                                 input logic [brb_pkg::LEN_W-1:0]  len_req,
                                 input logic [brb_pkg::OFF_W-1:0]  off);
    int      used;
    int      run;
    int      n;
    int      first;
    result_t r;
    used = held_bytes();
    r = '0;
    if (brb_pkg::mode_t'(m) == brb_pkg::MODE_WRITE) begin
      r.fin = 1'b1;
      if (used + 1 < DEPTH) begin
        byte_mem[AW'(head_ptr % DEPTH)] = d;
        head_ptr = (head_ptr + 1) % PTR_MOD;
        r.cnt = brb_pkg::LEN_W'(1);
      end
      r.lvl = brb_pkg::LVL_W'(held_bytes());
      expected_bytes.push_back(r);
    end else begin
      run = (int'(len_req) > MAX_RUN) ? MAX_RUN : int'(len_req);
      if (brb_pkg::mode_t'(m) == brb_pkg::MODE_PEEK) begin
        if (int'(off) >= used) n = 0;
        else n = (used - int'(off) < run) ? used - int'(off) : run;
        first = (tail_ptr + int'(off)) % DEPTH;
      end else begin
        n = (used < run) ? used : run;
        first = tail_ptr % DEPTH;
      end
      if (n == 0) begin
        r.fin = 1'b1;
        r.lvl = brb_pkg::LVL_W'(used);
        expected_bytes.push_back(r);
      end else begin
        if (brb_pkg::mode_t'(m) != brb_pkg::MODE_PEEK) tail_ptr = (tail_ptr + n) % PTR_MOD;
        used = held_bytes();
        for (int i = 0; i < n; i++) begin
          r.data = (brb_pkg::mode_t'(m) == brb_pkg::MODE_DISCARD) ?
                   '0 : byte_mem[AW'((first + i) % DEPTH)];
          r.fin  = (i == n - 1);
          r.cnt  = brb_pkg::LEN_W'(n);
          r.lvl  = brb_pkg::LVL_W'(used);
          expected_bytes.push_back(r);
        end
      end
    end
  endtask

  task automatic check_result();
    result_t e;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("result with nothing outstanding: byte %0h last %0b count %0d",
                                byte_out, last, count));
    end else begin
      e = expected_bytes.pop_front();
      if (byte_out !== e.data)
        report_mismatch($sformatf("byte_out %0h, want %0h", byte_out, e.data));
      if (last !== e.fin)
        report_mismatch($sformatf("last %0b, want %0b", last, e.fin));
      if (count !== e.cnt)
        report_mismatch($sformatf("count %0d, want %0d", count, e.cnt));
      if (used_level !== e.lvl)
        report_mismatch($sformatf("used_level %0d, want %0d", used_level, e.lvl));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_ptr = 0;
      tail_ptr = 0;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_request(mode, data_in, length, offset);
    end
    pending <= expected_bytes.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the byte ring buffer: clock, reset, request stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [brb_pkg::MODE_W-1:0] mode = '0;
  logic [brb_pkg::DATA_W-1:0] data_in = '0;
  logic [brb_pkg::LEN_W-1:0]  length = '0;
  logic [brb_pkg::OFF_W-1:0]  offset = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [brb_pkg::DATA_W-1:0] byte_out;
  logic                       last;
  logic [brb_pkg::LEN_W-1:0]  count;
  logic [brb_pkg::LVL_W-1:0]  used_level;

  int   fail_count;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_cnt = 0;

  byte_ring_buffer_with_peek uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .data_in   (data_in),
    .length    (length),
    .offset    (offset),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .byte_out  (byte_out),
    .last      (last),
    .count     (count),
    .used_level(used_level)
  );

  brb_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .data_in   (data_in),
    .length    (length),
    .offset    (offset),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .byte_out  (byte_out),
    .last      (last),
    .count     (count),
    .used_level(used_level),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= 400;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_request(input brb_pkg::mode_t m, input int d, input int len,
                              input int off);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    data_in  <= brb_pkg::DATA_W'(d);
    length   <= brb_pkg::LEN_W'(len);
    offset   <= brb_pkg::OFF_W'(off);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_request();
    int             r;
    int             len;
    int             off;
    brb_pkg::mode_t m;
    r = $urandom_range(99);
    if (r < 48) m = brb_pkg::MODE_WRITE;
    else if (r < 68) m = brb_pkg::MODE_READ;
    else if (r < 86) m = brb_pkg::MODE_PEEK;
    else m = brb_pkg::MODE_DISCARD;
    r = $urandom_range(99);
    if (r < 70) len = $urandom_range(0, 8);
    else if (r < 90) len = $urandom_range(9, 63);
    else len = 64;
    off = ($urandom_range(99) < 80) ? $urandom_range(0, 16) : $urandom_range(0, 4095);
    send_request(m, $urandom_range(0, 255), len, off);
  endtask

  task automatic set_idling(input int send_idle, input int recv_stall);
    idle_pct = send_idle;
    in_valid <= 1'b0;
    @(posedge clk);
    stall_pct <= recv_stall;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store, extremes, clamping
    set_idling(0, 0);
    send_request(brb_pkg::MODE_READ, 0, 5, 0);
    send_request(brb_pkg::MODE_PEEK, 0, 5, 0);
    send_request(brb_pkg::MODE_DISCARD, 0, 64, 0);
    send_request(brb_pkg::MODE_WRITE, 8'h00, 0, 0);
    send_request(brb_pkg::MODE_WRITE, 8'hFF, 127, 4095);
    send_request(brb_pkg::MODE_WRITE, 8'hA5, 0, 0);
    send_request(brb_pkg::MODE_WRITE, 8'h5A, 0, 0);
    send_request(brb_pkg::MODE_PEEK, 0, 0, 0);
    send_request(brb_pkg::MODE_READ, 0, 0, 0);
    send_request(brb_pkg::MODE_DISCARD, 0, 0, 0);
    send_request(brb_pkg::MODE_PEEK, 0, 64, 1);
    send_request(brb_pkg::MODE_PEEK, 0, 2, 3);
    send_request(brb_pkg::MODE_PEEK, 0, 2, 4);
    send_request(brb_pkg::MODE_PEEK, 0, 64, 4095);
    send_request(brb_pkg::MODE_READ, 0, 2, 0);
    send_request(brb_pkg::MODE_DISCARD, 0, 1, 0);
    send_request(brb_pkg::MODE_READ, 0, 64, 0);
    send_request(brb_pkg::MODE_READ, 0, 64, 0);
    send_request(brb_pkg::MODE_WRITE, 8'h3C, 0, 0);
    send_request(brb_pkg::MODE_PEEK, 0, 64, 0);

    // hold more than a run, then clamp long requests
    set_idling(0, 38);
    repeat (66) send_request(brb_pkg::MODE_WRITE, $urandom_range(0, 255), 0, 0);
    send_request(brb_pkg::MODE_PEEK, 0, 100, 3);
    send_request(brb_pkg::MODE_READ, 0, 127, 0);
    send_request(brb_pkg::MODE_DISCARD, 0, 127, 0);

    set_idling(0, 0);
    hold_req <= 1'b1;
    repeat (72) random_request();
    set_idling(76, 0);
    repeat (72) random_request();
    set_idling(0, 76);
    repeat (72) random_request();
    set_idling(38, 38);
    repeat (72) random_request();

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("[byte_ring_buffer_with_peek] OK");
    end else begin
      $display("[byte_ring_buffer_with_peek] ERROR");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("[byte_ring_buffer_with_peek] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/brb_pkg.sv
rtl/byte_ring_buffer_with_peek.sv
verif/brb_checker.sv
verif/tb.sv
